// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the warp block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bdw_pkg.sv -----
// Shared constants and stage types of the bilinear displacement warp.
package bdw_pkg;

  localparam int MaxSide   = 32;
  localparam int SideW     = $clog2(MaxSide);
  localparam int FracBits  = 8;
  localparam int PixW      = 8;
  localparam int ShiftW    = 16;
  localparam int PosW      = 18;            // signed row*S + shift, never overflows
  localparam int IntW      = PosW - 1 - FracBits;
  localparam int CfgW      = 6;
  localparam int CfgAddrW  = 2;
  localparam int NumBanks  = 4;
  localparam int BankSelW  = 2;
  localparam int BankAddrW = 2 * (SideW - 1);
  localparam int AccW      = 2 * PixW + 2;  // row-pass product and sum
  localparam int ValW      = 16;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 16;

  localparam logic [CfgAddrW-1:0] RegImageRows = 2'd0;
  localparam logic [CfgAddrW-1:0] RegImageCols = 2'd1;
  localparam logic [CfgW-1:0]     SideReset    = 6'd28;
  localparam logic [CfgW-1:0]     SideLimit    = CfgW'(MaxSide);

  typedef logic [NumBanks-1:0][BankAddrW-1:0] bank_addr_t;
  typedef logic [NumBanks-1:0][PixW-1:0]      bank_data_t;

  // Stage 1: decoded request with bank addresses.
  typedef struct packed {
    logic                sample;
    logic                oob;
    logic [FracBits-1:0] fr;
    logic [FracBits-1:0] fc;
    logic                r_par;
    logic                c_par;
    logic [BankSelW-1:0] wr_bank;
    logic [PixW-1:0]     wr_data;
    bank_addr_t          addr;
  } s1_t;

  // Stage 2: sample side info beside the bank read data.
  typedef struct packed {
    logic                oob;
    logic [FracBits-1:0] fr;
    logic [FracBits-1:0] fc;
    logic                r_par;
    logic                c_par;
  } s2_t;

endpackage

// ----- sv/bdw_bank.sv -----
// One pixel bank: 256 x 8 memory, one port, registered read data.
module bdw_bank (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          re_i,
  input  logic [bdw_pkg::BankAddrW-1:0] addr_i,
  input  logic [bdw_pkg::PixW-1:0]      wdata_i,
  output logic [bdw_pkg::PixW-1:0]      rdata_o
);

  logic [bdw_pkg::PixW-1:0] mem [2**bdw_pkg::BankAddrW];
  logic [bdw_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Hold read data while the stage behind it stalls.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bdw_addr.sv -----
// Stage 1: displaced position, bounds check and four-bank neighbor addresses.
module bdw_addr (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        req_type_i,
  input  logic [bdw_pkg::SideW-1:0]   row_i,
  input  logic [bdw_pkg::SideW-1:0]   col_i,
  input  logic [bdw_pkg::PixW-1:0]    pixel_in_i,
  input  logic [bdw_pkg::ShiftW-1:0]  shift_row_i,
  input  logic [bdw_pkg::ShiftW-1:0]  shift_col_i,
  input  logic [bdw_pkg::CfgW-1:0]    image_rows_i,
  input  logic [bdw_pkg::CfgW-1:0]    image_cols_i,
  output bdw_pkg::s1_t                s1_o
);

  bdw_pkg::s1_t s1_d, s1_q;

  logic signed [bdw_pkg::PosW-1:0] pos_r, pos_c;
  logic [bdw_pkg::IntW-1:0]        r0_full, c0_full;
  logic [bdw_pkg::CfgW-1:0]        rows_lim, cols_lim;
  logic                            row_bad, col_bad;
  logic [bdw_pkg::SideW-1:0]       r0, r1, c0, c1;

  assign pos_r = $signed({{(bdw_pkg::PosW - bdw_pkg::SideW - bdw_pkg::FracBits){1'b0}},
                          row_i, {bdw_pkg::FracBits{1'b0}}})
               + bdw_pkg::PosW'($signed(shift_row_i));
  assign pos_c = $signed({{(bdw_pkg::PosW - bdw_pkg::SideW - bdw_pkg::FracBits){1'b0}},
                          col_i, {bdw_pkg::FracBits{1'b0}}})
               + bdw_pkg::PosW'($signed(shift_col_i));

  assign r0_full = pos_r[bdw_pkg::PosW-2:bdw_pkg::FracBits];
  assign c0_full = pos_c[bdw_pkg::PosW-2:bdw_pkg::FracBits];

  assign rows_lim = (image_rows_i > bdw_pkg::SideLimit) ? bdw_pkg::SideLimit : image_rows_i;
  assign cols_lim = (image_cols_i > bdw_pkg::SideLimit) ? bdw_pkg::SideLimit : image_cols_i;

  // The floor+1 neighbor has to sit inside the image.
  assign row_bad = ({1'b0, r0_full} + 1'b1) >= (bdw_pkg::IntW + 1)'(rows_lim);
  assign col_bad = ({1'b0, c0_full} + 1'b1) >= (bdw_pkg::IntW + 1)'(cols_lim);

  assign r0 = r0_full[bdw_pkg::SideW-1:0];
  assign c0 = c0_full[bdw_pkg::SideW-1:0];
  assign r1 = r0 + 1'b1;
  assign c1 = c0 + 1'b1;

  always_comb begin
    logic [bdw_pkg::SideW-1:0] rsel, csel;
    s1_d         = '0;
    s1_d.sample  = req_type_i;
    s1_d.oob     = pos_r[bdw_pkg::PosW-1] | pos_c[bdw_pkg::PosW-1] | row_bad | col_bad;
    s1_d.fr      = pos_r[bdw_pkg::FracBits-1:0];
    s1_d.fc      = pos_c[bdw_pkg::FracBits-1:0];
    s1_d.r_par   = r0[0];
    s1_d.c_par   = c0[0];
    s1_d.wr_bank = {row_i[0], col_i[0]};
    s1_d.wr_data = pixel_in_i;
    for (int b = 0; b < bdw_pkg::NumBanks; b++) begin
      // Bank b holds row parity b[1] and column parity b[0].
      rsel = (r0[0] == b[1]) ? r0 : r1;
      csel = (c0[0] == b[0]) ? c0 : c1;
      if (req_type_i) begin
        s1_d.addr[b] = {rsel[bdw_pkg::SideW-1:1], csel[bdw_pkg::SideW-1:1]};
      end else begin
        s1_d.addr[b] = {row_i[bdw_pkg::SideW-1:1], col_i[bdw_pkg::SideW-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// ----- sv/bdw_interp.sv -----
// Stages 3 and 4: row pass then column pass of the bilinear interpolation.
module bdw_interp (
  input  logic                          clk_i,
  input  logic                          en3_i,
  input  logic                          en4_i,
  input  bdw_pkg::s2_t                  s2_i,
  input  bdw_pkg::bank_data_t           rdata_i,
  output logic [bdw_pkg::ValW-1:0]      value_o,
  output logic                          oob_o
);

  logic [bdw_pkg::PixW-1:0] p00, p01, p10, p11;

  logic signed [bdw_pkg::PixW:0]   d0, d1;
  logic signed [bdw_pkg::AccW-1:0] pr0, pr1, a_full, b_full;

  logic [bdw_pkg::ValW-1:0]     a_q, b_q;
  logic [bdw_pkg::FracBits-1:0] fc3_q;
  logic                         oob3_q;

  logic signed [bdw_pkg::ValW:0]                       dab;
  logic signed [bdw_pkg::ValW+bdw_pkg::FracBits+1:0]   pc;
  logic signed [bdw_pkg::ValW+bdw_pkg::FracBits+2:0]   v_full;

  logic [bdw_pkg::ValW-1:0] val_q;
  logic                     oob4_q;

  // Pick the four neighbors out of the parity banks.
  assign p00 = rdata_i[{s2_i.r_par, s2_i.c_par}];
  assign p01 = rdata_i[{s2_i.r_par, ~s2_i.c_par}];
  assign p10 = rdata_i[{~s2_i.r_par, s2_i.c_par}];
  assign p11 = rdata_i[{~s2_i.r_par, ~s2_i.c_par}];

  assign d0  = $signed({1'b0, p10}) - $signed({1'b0, p00});
  assign d1  = $signed({1'b0, p11}) - $signed({1'b0, p01});
  assign pr0 = bdw_pkg::AccW'(d0 * $signed({1'b0, s2_i.fr}));
  assign pr1 = bdw_pkg::AccW'(d1 * $signed({1'b0, s2_i.fr}));

  // Convex blend of two pixels: never negative, fits Q8.8.
  assign a_full = $signed({2'b00, p00, {bdw_pkg::FracBits{1'b0}}}) + pr0;
  assign b_full = $signed({2'b00, p01, {bdw_pkg::FracBits{1'b0}}}) + pr1;

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      a_q    <= a_full[bdw_pkg::ValW-1:0];
      b_q    <= b_full[bdw_pkg::ValW-1:0];
      fc3_q  <= s2_i.fc;
      oob3_q <= s2_i.oob;
    end
  end

  assign dab    = $signed({1'b0, b_q}) - $signed({1'b0, a_q});
  assign pc     = dab * $signed({1'b0, fc3_q});
  assign v_full = $signed({3'b000, a_q, {bdw_pkg::FracBits{1'b0}}}) + $signed({pc[$high(pc)], pc});

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      val_q  <= oob3_q ? '0 : v_full[bdw_pkg::ValW+bdw_pkg::FracBits-1:bdw_pkg::FracBits];
      oob4_q <= oob3_q;
    end
  end

  assign value_o = val_q;
  assign oob_o   = oob4_q;

endmodule

// ----- sv/bilinear_displacement_warp.sv -----
// Top level: pixel store and bilinear displacement sampler, four-stage pipeline.
//
//  port group   dir  fields (low bit first)
//  s_axis_*     in   tdata: row[4:0] col[9:5] pixel_in[17:10] shift_row[33:18]
//                    shift_col[49:34] zero[55:50]; tuser: req_type
//  m_axis_*     out  tdata: sample_value[15:0]; tuser: out_of_bounds
//  cfg_*        in   addr: 0 image_rows, 1 image_cols; data: 6-bit count
//
// One item per cycle unless m_axis stalls; a sample's result passes through every stage
// register in turn before it is valid on m_axis.
// Stages: position and bank addresses, four-bank pixel read, row pass, column pass.
// Writes leave the pipeline after the bank write and give no result.
// A stall at m_axis holds the output stage; earlier items advance into empty stages
// and hold once the stage ahead is full.
// Reset clears valid bits and sets both counts to 28; pixels are undefined until written.
`include "assert_macros.svh"

module bilinear_displacement_warp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdw_pkg::InDataW-1:0]     s_axis_tdata,   // row, col, pixel_in, shift_row, shift_col
  input  logic                            s_axis_tuser,   // req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bdw_pkg::OutDataW-1:0]    m_axis_tdata,   // sample_value
  output logic                            m_axis_tuser,   // out_of_bounds
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bdw_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [bdw_pkg::CfgW-1:0]        cfg_data_i
);

  logic [bdw_pkg::CfgW-1:0] rows_q, cols_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic fire2;

  bdw_pkg::s1_t       s1;
  bdw_pkg::s2_t       s2_q;
  bdw_pkg::bank_data_t rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= bdw_pkg::SideReset;
      cols_q <= bdw_pkg::SideReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        bdw_pkg::RegImageRows: rows_q <= cfg_data_i;
        bdw_pkg::RegImageCols: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage takes a new item when empty or when it moves on.
  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign fire2 = v1_q && rdy2;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q && s1.sample;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  bdw_addr u_addr (
    .clk_i        (clk_i),
    .en_i         (rdy1),
    .req_type_i   (s_axis_tuser),
    .row_i        (s_axis_tdata[4:0]),
    .col_i        (s_axis_tdata[9:5]),
    .pixel_in_i   (s_axis_tdata[17:10]),
    .shift_row_i  (s_axis_tdata[33:18]),
    .shift_col_i  (s_axis_tdata[49:34]),
    .image_rows_i (rows_q),
    .image_cols_i (cols_q),
    .s1_o         (s1)
  );

  for (genvar b = 0; b < bdw_pkg::NumBanks; b++) begin : g_bank
    bdw_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (fire2 && !s1.sample && (s1.wr_bank == bdw_pkg::BankSelW'(b))),
      .re_i    (fire2 && s1.sample),
      .addr_i  (s1.addr[b]),
      .wdata_i (s1.wr_data),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (fire2) begin
      s2_q.oob   <= s1.oob;
      s2_q.fr    <= s1.fr;
      s2_q.fc    <= s1.fc;
      s2_q.r_par <= s1.r_par;
      s2_q.c_par <= s1.c_par;
    end
  end

  bdw_interp u_interp (
    .clk_i   (clk_i),
    .en3_i   (rdy3),
    .en4_i   (rdy4),
    .s2_i    (s2_q),
    .rdata_i (rdata),
    .value_o (m_axis_tdata),
    .oob_o   (m_axis_tuser)
  );

  assign m_axis_tvalid = v4_q;

  `BDW_ASSERT_NXT(a_write_no_result, clk_i, rst_ni, fire2 && !s1.sample, !v2_q, "pixel write entered the sample path")
  `BDW_ASSERT_IMP(a_oob_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "out-of-bounds sample with nonzero value")
  `BDW_ASSERT_IMP(a_value_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata <= 16'hFF00, "interpolated value above full scale")

endmodule

// ----- dv/bilinear_displacement_warp_tb.sv -----
// Self-checking testbench for the bilinear displacement warp: directed table, then random phases.
`timescale 1ns / 1ps

module bilinear_displacement_warp_tb;

  localparam int MaxSide  = bdw_pkg::MaxSide;
  localparam int SideW    = bdw_pkg::SideW;
  localparam int FracBits = bdw_pkg::FracBits;
  localparam int PixW     = bdw_pkg::PixW;
  localparam int ShiftW   = bdw_pkg::ShiftW;
  localparam int ValW     = bdw_pkg::ValW;
  localparam int CfgW     = bdw_pkg::CfgW;
  localparam int CfgAddrW = bdw_pkg::CfgAddrW;
  localparam int InDataW  = bdw_pkg::InDataW;
  localparam int OutDataW = bdw_pkg::OutDataW;
  localparam logic [CfgW-1:0]     SideReset    = bdw_pkg::SideReset;
  localparam logic [CfgAddrW-1:0] RegImageRows = bdw_pkg::RegImageRows;
  localparam logic [CfgAddrW-1:0] RegImageCols = bdw_pkg::RegImageCols;

  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqSample = 1'b1;
  localparam logic [CfgAddrW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSpare3 = 2'd3;
  localparam logic UsePredictor = 1'b0;
  localparam logic UseLiteral   = 1'b1;

  localparam int Scale         = 1 << FracBits;
  localparam int PipeLatency   = 4;
  localparam int SettleCycles  = 4 * PipeLatency;
  localparam int RandItems     = 2000;
  localparam int NumPhases     = 9;
  localparam int HoldOffCycles = 400;
  localparam int HoldOffAfter  = 60;
  localparam int CycleLimit    = 1_500_000;
  localparam int ReportMax     = 10;
  localparam int NumDirected   = 24;

  localparam int PhaseRows [NumPhases] = '{32, 63, 2, 1, 0, 63, 17, 20, 0};
  localparam int PhaseCols [NumPhases] = '{32, 63, 2, 31, 32, 1, 9, 63, 0};

  typedef struct packed {
    logic              req;
    logic [SideW-1:0]  row;
    logic [SideW-1:0]  col;
    logic [PixW-1:0]   pix;
    logic [ShiftW-1:0] shift_row;
    logic [ShiftW-1:0] shift_col;
  } warp_req_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            oob;
  } warp_res_t;

  typedef struct packed {
    warp_req_t rq;
    logic      lit;
    warp_res_t res;
  } dir_row_t;

  localparam warp_res_t NoRes  = '{value: '0, oob: 1'b0};
  localparam warp_res_t OobRes = '{value: '0, oob: 1'b1};

  // Reset counts are 28 x 28 throughout this table.
  dir_row_t dir_tab [NumDirected] = '{
    '{'{ReqWrite,  5'd0,  5'd0,  8'hFF, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd1,  5'd0,  8'h00, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd0,  5'd1,  8'h00, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd1,  5'd1,  8'hFF, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0000, 16'h0000}, UseLiteral,
      '{value: 16'hFF00, oob: 1'b0}},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0080, 16'h0080}, UsePredictor, NoRes},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h00FF, 16'h00FF}, UsePredictor, NoRes},
    // negative position on either axis
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'hFFFF, 16'h0000}, UseLiteral, OobRes},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0000, 16'h8000}, UseLiteral, OobRes},
    // far beyond the image
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h7FFF, 16'h0000}, UseLiteral, OobRes},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0000, 16'h7FFF}, UseLiteral, OobRes},
    // floor+1 neighbor just past the last row / column
    '{'{ReqSample, 5'd27, 5'd0,  8'h00, 16'h0000, 16'h0000}, UseLiteral, OobRes},
    '{'{ReqSample, 5'd0,  5'd27, 8'h00, 16'h0000, 16'h0000}, UseLiteral, OobRes},
    // stored even though outside the active image
    '{'{ReqWrite,  5'd31, 5'd31, 8'hAA, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd30, 5'd30, 8'h55, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd31, 5'd30, 8'h00, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd30, 5'd31, 8'hFF, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    // output position outside the image, displaced back to the origin
    '{'{ReqSample, 5'd31, 5'd31, 8'h00, 16'hE100, 16'hE100}, UseLiteral,
      '{value: 16'hFF00, oob: 1'b0}},
    // read right behind a write to the same pixel
    '{'{ReqWrite,  5'd0,  5'd0,  8'h10, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0000, 16'h0000}, UseLiteral,
      '{value: 16'h1000, oob: 1'b0}},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0040, 16'h00C0}, UsePredictor, NoRes},
    '{'{ReqWrite,  5'd0,  5'd1,  8'hFF, 16'h0000, 16'h0000}, UsePredictor, NoRes},
    '{'{ReqSample, 5'd0,  5'd0,  8'h00, 16'h0000, 16'h0080}, UsePredictor, NoRes},
    '{'{ReqSample, 5'd1,  5'd1,  8'h00, 16'hFF00, 16'hFF00}, UsePredictor, NoRes}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataW-1:0]     s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataW-1:0]    m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgAddrW-1:0]    cfg_addr_i    = '0;
  logic [CfgW-1:0]        cfg_data_i    = '0;

  logic [PixW-1:0] pix_mirror  [MaxSide*MaxSide];
  bit              pix_written [MaxSide*MaxSide];
  int              img_rows = int'(SideReset);
  int              img_cols = int'(SideReset);

  warp_res_t expected_samples [$];
  int errors        = 0;
  int writes_sent   = 0;
  int samples_seen  = 0;
  int oob_seen      = 0;
  int settings_used = 1;
  int cycle_count   = 0;

  bilinear_displacement_warp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 85) return int'($urandom_range(1, 3));
    if (roll < 95) return int'($urandom_range(4, 10));
    return int'($urandom_range(15, 40));
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 15) return '0;
    if (roll < 30) return '1;
    return PixW'($urandom);
  endfunction

  function automatic longint pixel_at(input int r, input int c);
    if (r >= MaxSide || c >= MaxSide) return 0;
    return longint'(pix_mirror[r*MaxSide + c]);
  endfunction

  // Bilinear sample of the mirrored image; r0/c0 name the top-left neighbor.
  function automatic warp_res_t interp_sample(input warp_req_t rq, output int r0, output int c0);
    warp_res_t res;
    longint    p, q, a, b, v;
    int        fr, fc, nr, nc;
    res = OobRes;
    r0 = 0;
    c0 = 0;
    nr = (img_rows > MaxSide) ? MaxSide : img_rows;
    nc = (img_cols > MaxSide) ? MaxSide : img_cols;
    p = longint'(rq.row) * Scale + longint'($signed(rq.shift_row));
    q = longint'(rq.col) * Scale + longint'($signed(rq.shift_col));
    if (p < 0 || q < 0) return res;
    r0 = int'(p / Scale);
    fr = int'(p % Scale);
    c0 = int'(q / Scale);
    fc = int'(q % Scale);
    if (r0 + 1 >= nr || c0 + 1 >= nc) return res;
    a = pixel_at(r0, c0) * Scale + fr * (pixel_at(r0 + 1, c0) - pixel_at(r0, c0));
    if (a < 0) a = 0;
    b = pixel_at(r0, c0 + 1) * Scale
        + fr * (pixel_at(r0 + 1, c0 + 1) - pixel_at(r0, c0 + 1));
    if (b < 0) b = 0;
    v = a * Scale + fc * (b - a);
    if (v < 0) v = 0;
    v = v / Scale;
    if (v > 64'hFFFF) v = 64'hFFFF;
    res.value = ValW'(v);
    res.oob   = 1'b0;
    return res;
  endfunction

  task automatic note_failure(input string what);
    errors++;
    if (errors <= ReportMax) $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Offer one item after a random gap; on transfer update the mirror or queue the result.
  task automatic send_request(input warp_req_t rq, input logic lit, input warp_res_t lit_res);
    int        gap, r0, c0, idx;
    warp_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({rq.shift_col, rq.shift_row, rq.pix, rq.col, rq.row});
    s_axis_tuser  <= rq.req;
    do @(posedge clk_i); while (!s_axis_tready);
    if (rq.req == ReqWrite) begin
      idx = int'(rq.row) * MaxSide + int'(rq.col);
      pix_mirror[idx]  = rq.pix;
      pix_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      res = interp_sample(rq, r0, c0);
      expected_samples.push_back(lit ? lit_res : res);
    end
  endtask

  task automatic apply_count(input logic [CfgAddrW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegImageRows) img_rows = int'(val);
    if (idx == RegImageCols) img_cols = int'(val);
    @(posedge clk_i);
  endtask

  // Writes give no result, so wait out the pipeline once the queue is empty.
  task automatic settle_pipeline();
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_item();
    warp_req_t rq, fill;
    warp_res_t probe;
    int        roll, p, q, nr, nc, r0, c0, idx;
    rq.row       = SideW'($urandom);
    rq.col       = SideW'($urandom);
    rq.pix       = pick_pixel();
    rq.shift_row = ShiftW'($urandom);
    rq.shift_col = ShiftW'($urandom);
    if ($urandom_range(0, 99) < 30) begin
      rq.req = ReqWrite;
      send_request(rq, UsePredictor, NoRes);
    end else begin
      rq.req = ReqSample;
      nr = (img_rows > MaxSide) ? MaxSide : img_rows;
      nc = (img_cols > MaxSide) ? MaxSide : img_cols;
      roll = int'($urandom_range(0, 99));
      if (roll < 75 && nr >= 2 && nc >= 2) begin
        // land inside the image
        p = int'($urandom_range(0, (nr - 1) * Scale - 1));
        q = int'($urandom_range(0, (nc - 1) * Scale - 1));
        rq.shift_row = ShiftW'(p - int'(rq.row) * Scale);
        rq.shift_col = ShiftW'(q - int'(rq.col) * Scale);
      end else if (roll < 88) begin
        // straddle the last valid neighbor
        p = (nr - 1) * Scale + int'($urandom_range(0, 2 * Scale - 1)) - Scale;
        q = (nc - 1) * Scale + int'($urandom_range(0, 2 * Scale - 1)) - Scale;
        rq.shift_row = ShiftW'(p - int'(rq.row) * Scale);
        rq.shift_col = ShiftW'(q - int'(rq.col) * Scale);
      end
      // write any neighbor the sample reads that was never written
      probe = interp_sample(rq, r0, c0);
      if (!probe.oob) begin
        for (int dr = 0; dr < 2; dr++) begin
          for (int dc = 0; dc < 2; dc++) begin
            idx = (r0 + dr) * MaxSide + c0 + dc;
            if (!pix_written[idx]) begin
              fill.req       = ReqWrite;
              fill.row       = SideW'(r0 + dr);
              fill.col       = SideW'(c0 + dc);
              fill.pix       = pick_pixel();
              fill.shift_row = ShiftW'($urandom);
              fill.shift_col = ShiftW'($urandom);
              send_request(fill, UsePredictor, NoRes);
            end
          end
        end
      end
      send_request(rq, UsePredictor, NoRes);
    end
  endtask

  // Result monitor: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    warp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      samples_seen++;
      if (m_axis_tuser) oob_seen++;
      if (expected_samples.size() == 0) begin
        note_failure($sformatf("unexpected result value %h oob %b", m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_samples.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.oob)
          note_failure($sformatf("expected value %h oob %b, got value %h oob %b",
                                 want.value, want.oob, m_axis_tdata, m_axis_tuser));
      end
    end
  end

  // Result-side backpressure, with one long hold-off to fill the pipeline.
  initial begin
    int  burst, gap;
    bit  held_off;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && samples_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      burst = ($urandom_range(0, 99) < 70) ? int'($urandom_range(1, 8))
                                           : int'($urandom_range(20, 80));
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_samples.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [CfgW-1:0] rows_val, cols_val;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      send_request(dir_tab[i].rq, dir_tab[i].lit, dir_tab[i].res);

    for (int ph = 0; ph < NumPhases; ph++) begin
      s_axis_tvalid <= 1'b0;
      settle_pipeline();
      rows_val = (ph == NumPhases - 1) ? CfgW'($urandom) : CfgW'(PhaseRows[ph]);
      cols_val = (ph == NumPhases - 1) ? CfgW'($urandom) : CfgW'(PhaseCols[ph]);
      // unused indexes must leave both counts alone
      apply_count(RegSpare2, CfgW'($urandom));
      apply_count(RegSpare3, CfgW'($urandom));
      apply_count(RegImageRows, rows_val);
      apply_count(RegImageCols, cols_val);
      settings_used++;
      for (int k = 0; k < RandItems / NumPhases; k++) random_item();
    end
    s_axis_tvalid <= 1'b0;
    settle_pipeline();

    $display("Covered %0d pixel writes and %0d samples (%0d out of bounds)",
             writes_sent, samples_seen, oob_seen);
    $display("across %0d image size settings, %0d errors", settings_used, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- bilinear_displacement_warp.f -----
+incdir+sv
sv/bdw_pkg.sv
sv/bdw_bank.sv
sv/bdw_addr.sv
sv/bdw_interp.sv
sv/bilinear_displacement_warp.sv
dv/bilinear_displacement_warp_tb.sv
